@@ sv/dfcc_pkg.sv @@
// Shared types, constants and the ones'-complement adder for the DHCP frame classifier.
// Used by the front end, the queue, the back end and the top level; depends on nothing.
package dfcc_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       forward;
  } in_item_t;

  typedef enum logic [1:0] {
    VERDICT_NONE     = 2'd0,
    VERDICT_LOCAL    = 2'd1,
    VERDICT_REQUEST  = 2'd2,
    VERDICT_RESPONSE = 2'd3
  } verdict_e;

  typedef struct packed {
    verdict_e    verdict;
    logic [6:0]  udp_offset;
    logic [15:0] udp_checksum;
    logic [47:0] source_mac;
    logic [31:0] source_ip;
  } out_item_t;

  typedef enum logic [2:0] {
    CLS_SKIP,
    CLS_MAC,
    CLS_IP_HI,
    CLS_IP_LO,
    CLS_DST_HI,
    CLS_DST_LO,
    CLS_UDP
  } byte_class_e;

  typedef struct packed {
    byte_class_e cls;
    logic [15:0] rel;
    logic [7:0]  data;
    logic        last;
    logic        fwd;
    logic        hdr_ok;
    logic        len_ok;
    logic [6:0]  udp_off;
  } q_entry_t;

  localparam logic [6:0] ETH_HDR_BYTES = 7'd14;
  localparam int unsigned UDP_MIN_BYTES = 20;

  localparam int unsigned POS_MAC_FIRST = 6;
  localparam int unsigned POS_MAC_LAST  = 11;
  localparam int unsigned POS_TYPE_HI   = 12;
  localparam int unsigned POS_TYPE_LO   = 13;
  localparam int unsigned POS_VER_IHL   = 14;
  localparam int unsigned POS_PROTO     = 23;
  localparam int unsigned POS_SIP_FIRST = 26;
  localparam int unsigned POS_SIP_LAST  = 29;
  localparam int unsigned POS_DIP_LAST  = 33;

  localparam logic [7:0] ETHERTYPE_HI = 8'h08;
  localparam logic [7:0] ETHERTYPE_LO = 8'h00;
  localparam logic [3:0] IP_VERSION   = 4'd4;
  localparam logic [3:0] MIN_IHL      = 4'd5;
  localparam logic [7:0] PROTO_UDP    = 8'd17;

  localparam logic [15:0] REL_DPORT_LO = 16'd3;
  localparam logic [15:0] REL_LEN_HI   = 16'd4;
  localparam logic [15:0] REL_LEN_LO   = 16'd5;
  localparam logic [15:0] REL_SRC_WORD = 16'd6;
  localparam logic [15:0] REL_DST_WORD = 16'd7;
  localparam logic [15:0] REL_OPCODE   = 16'd8;
  localparam logic [15:0] REL_FLAGS    = 16'd18;

  localparam logic [15:0] DHCP_PORT    = 16'd67;
  localparam logic [15:0] PSEUDO_PROTO = 16'd17;
  localparam logic [7:0]  OP_REQUEST   = 8'd1;
  localparam logic [7:0]  OP_REPLY     = 8'd2;
  localparam logic [7:0]  BCAST_FLAG   = 8'h80;
  localparam logic [15:0] SUM_ALL_ONES = 16'hffff;

  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

@@ sv/dfcc_front.sv @@
// Front end: tracks the byte position and IP header length, checks the fixed header fields
// and tags each accepted byte with its role before queueing it. Depends on dfcc_pkg.
module dfcc_front
  import dfcc_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = 2048
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_data_i,
  input  logic     q_full_i,
  output logic     q_push_o,
  output q_entry_t q_entry_o
);

  localparam int unsigned PW = $clog2(MAX_FRAME_BYTES + 1);

  logic [PW-1:0] pos_q, pos_d;
  logic [3:0]    ihl_q, ihl_d;
  logic          hdr_ok_q, hdr_ok_d;
  logic [16:0]   pos_w;
  logic [6:0]    udp_off;
  logic          over;
  logic [7:0]    b;
  byte_class_e   cls;

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    b        = in_data_i.data_byte;
    pos_w    = 17'(pos_q);
    udp_off  = ETH_HDR_BYTES + {1'b0, ihl_q, 2'b00};
    over     = pos_w >= 17'(MAX_FRAME_BYTES);
    pos_d    = pos_q;
    ihl_d    = ihl_q;
    hdr_ok_d = hdr_ok_q;
    cls      = CLS_SKIP;
    if (over) begin
      hdr_ok_d = 1'b0;
    end else begin
      pos_d = pos_q + PW'(1);
      priority if (pos_w >= 17'(POS_MAC_FIRST) && pos_w <= 17'(POS_MAC_LAST)) begin
        cls = CLS_MAC;
      end else if (pos_w == 17'(POS_TYPE_HI) && b != ETHERTYPE_HI) begin
        hdr_ok_d = 1'b0;
      end else if (pos_w == 17'(POS_TYPE_LO) && b != ETHERTYPE_LO) begin
        hdr_ok_d = 1'b0;
      end else if (pos_w == 17'(POS_VER_IHL)) begin
        ihl_d = b[3:0];
        if (b[7:4] != IP_VERSION || b[3:0] < MIN_IHL) begin
          hdr_ok_d = 1'b0;
        end
      end else if (pos_w == 17'(POS_PROTO) && b != PROTO_UDP) begin
        hdr_ok_d = 1'b0;
      end else if (pos_w >= 17'(POS_SIP_FIRST) && pos_w <= 17'(POS_SIP_LAST)) begin
        cls = pos_w[0] ? CLS_IP_LO : CLS_IP_HI;
      end else if (pos_w > 17'(POS_SIP_LAST) && pos_w <= 17'(POS_DIP_LAST)) begin
        cls = pos_w[0] ? CLS_DST_LO : CLS_DST_HI;
      end else if (ihl_q >= MIN_IHL && pos_w >= 17'(udp_off)) begin
        cls = CLS_UDP;
      end else begin
        cls = CLS_SKIP;
      end
    end
  end

  always_comb begin
    q_entry_o.cls     = cls;
    q_entry_o.rel     = 16'(pos_q) - {9'd0, udp_off};
    q_entry_o.data    = b;
    q_entry_o.last    = in_data_i.last_byte;
    q_entry_o.fwd     = in_data_i.forward;
    q_entry_o.hdr_ok  = hdr_ok_d;
    q_entry_o.len_ok  = pos_w >= 17'(udp_off) + 17'(UDP_MIN_BYTES - 1);
    q_entry_o.udp_off = udp_off;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      ihl_q    <= '0;
      hdr_ok_q <= 1'b1;
    end else if (q_push_o) begin
      if (in_data_i.last_byte) begin
        pos_q    <= '0;
        ihl_q    <= '0;
        hdr_ok_q <= 1'b1;
      end else begin
        pos_q    <= pos_d;
        ihl_q    <= ihl_d;
        hdr_ok_q <= hdr_ok_d;
      end
    end
  end

endmodule

@@ sv/dfcc_queue.sv @@
// Short first-in first-out queue of tagged bytes between the front and back ends.
// Depends on dfcc_pkg for the entry type.
module dfcc_queue
  import dfcc_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t entry_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output q_entry_t entry_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  q_entry_t        slots_q [DEPTH];
  logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   count_q;

  assign full_o  = count_q == CW'(DEPTH);
  assign valid_o = count_q != '0;
  assign entry_o = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

endmodule

@@ sv/dfcc_back.sv @@
// Back end: keeps the UDP and DHCP fields, the source addresses and the checksum sums,
// then forms the verdict through a final stage and an output register. Depends on dfcc_pkg.
module dfcc_back
  import dfcc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  q_entry_t  q_entry_i,
  output logic      q_pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam logic [15:0] LEN_SRC_PART = 16'd1;
  localparam logic [15:0] LEN_DST_PART = 16'd3;
  localparam logic [15:0] LEN_LEN_PART = 16'd5;

  logic [15:0] udp_len_q, udp_len_d;
  logic        port_match_q, port_match_d;
  logic [7:0]  opcode_q, opcode_d;
  logic [15:0] sum_q, sum_d;
  logic [15:0] hdr_q, hdr_d;
  logic [7:0]  pending_q, pending_d;
  logic [47:0] mac_q, mac_d;
  logic [31:0] ip_q, ip_d;
  logic [31:0] ports_q, ports_d;

  logic        fin_valid_q;
  logic        fin_ok_q, fin_fwd_q, fin_req_q;
  logic [6:0]  fin_off_q;
  logic [47:0] fin_mac_q;
  logic [31:0] fin_ip_q;
  logic [15:0] fin_sum_q, fin_hdr_q;

  logic        out_valid_q;
  out_item_t   out_item_q, out_item_d;

  q_entry_t    e;
  logic [7:0]  b, bb;
  logic        ok, out_ready, fin_ready, fin_move;
  logic [15:0] total, folded;
  verdict_e    verdict;

  function automatic logic [15:0] hdr_word(input logic [15:0] w, input logic [15:0] len,
                                           input logic [15:0] part);
    logic [15:0] r;
    r = '0;
    if (len > part) begin
      r = w;
    end else if (len == part) begin
      r = {w[15:8], 8'h00};
    end
    return r;
  endfunction

  assign out_ready   = !out_valid_q || !out_stall_i;
  assign fin_ready   = !fin_valid_q || out_ready;
  assign fin_move    = fin_valid_q && out_ready;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

  always_comb begin
    e            = q_entry_i;
    b            = e.data;
    bb           = (e.rel == REL_FLAGS) ? (b | BCAST_FLAG) : b;
    q_pop_o      = q_valid_i && (!e.last || fin_ready);
    udp_len_d    = udp_len_q;
    port_match_d = port_match_q;
    opcode_d     = opcode_q;
    sum_d        = sum_q;
    hdr_d        = hdr_q;
    pending_d    = pending_q;
    mac_d        = mac_q;
    ip_d         = ip_q;
    ports_d      = ports_q;
    unique case (e.cls)
      CLS_SKIP: begin
      end
      CLS_MAC: begin
        mac_d = {mac_q[39:0], b};
      end
      CLS_IP_HI: begin
        ip_d      = {ip_q[23:0], b};
        pending_d = b;
      end
      CLS_IP_LO: begin
        ip_d  = {ip_q[23:0], b};
        sum_d = oc_add(sum_q, {pending_q, b});
      end
      CLS_DST_HI: begin
        pending_d = b;
      end
      CLS_DST_LO: begin
        sum_d = oc_add(sum_q, {pending_q, b});
      end
      CLS_UDP: begin
        priority if (e.rel < REL_LEN_HI) begin
          ports_d = {ports_q[23:0], b};
          if (e.rel == REL_DPORT_LO) begin
            port_match_d = ports_d[31:16] == DHCP_PORT || ports_d[15:0] == DHCP_PORT;
          end
        end else if (e.rel == REL_LEN_HI) begin
          udp_len_d = {b, 8'h00};
        end else if (e.rel == REL_LEN_LO) begin
          udp_len_d = {udp_len_q[15:8], b};
          hdr_d     = udp_len_d + PSEUDO_PROTO;
          sum_d     = oc_add(sum_q, hdr_word(ports_q[31:16], udp_len_d, LEN_SRC_PART));
        end else if (e.rel == REL_SRC_WORD) begin
          sum_d = oc_add(sum_q, hdr_word(ports_q[15:0], udp_len_q, LEN_DST_PART));
        end else if (e.rel == REL_DST_WORD) begin
          sum_d = oc_add(sum_q, hdr_word(udp_len_q, udp_len_q, LEN_LEN_PART));
        end else begin
          if (e.rel == REL_OPCODE) begin
            opcode_d = b;
          end
          if (e.rel < udp_len_q) begin
            if (!e.rel[0]) begin
              if (17'(e.rel) + 17'd1 == 17'(udp_len_q)) begin
                sum_d = oc_add(sum_q, {bb, 8'h00});
              end else begin
                pending_d = bb;
              end
            end else begin
              sum_d = oc_add(sum_q, {pending_q, bb});
            end
          end
        end
      end
    endcase
    ok = e.hdr_ok && e.len_ok && (17'(udp_len_d) <= 17'(e.rel) + 17'd1) && port_match_d &&
         (opcode_d == OP_REQUEST || opcode_d == OP_REPLY);
  end

  always_comb begin
    total  = oc_add(fin_sum_q, fin_hdr_q);
    folded = (total == '0) ? SUM_ALL_ONES : total;
    priority if (!fin_ok_q) begin
      verdict = VERDICT_NONE;
    end else if (!fin_fwd_q) begin
      verdict = VERDICT_LOCAL;
    end else if (fin_req_q) begin
      verdict = VERDICT_REQUEST;
    end else begin
      verdict = VERDICT_RESPONSE;
    end
    out_item_d.verdict      = verdict;
    out_item_d.udp_offset   = fin_ok_q ? fin_off_q : '0;
    out_item_d.udp_checksum = (verdict == VERDICT_REQUEST || verdict == VERDICT_RESPONSE) ?
                              ~folded : '0;
    out_item_d.source_mac   = fin_ok_q ? fin_mac_q : '0;
    out_item_d.source_ip    = fin_ok_q ? fin_ip_q : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      udp_len_q    <= '0;
      port_match_q <= 1'b0;
      opcode_q     <= '0;
      sum_q        <= '0;
      hdr_q        <= '0;
      pending_q    <= '0;
      mac_q        <= '0;
      ip_q         <= '0;
      ports_q      <= '0;
    end else if (q_pop_o) begin
      if (e.last) begin
        udp_len_q    <= '0;
        port_match_q <= 1'b0;
        opcode_q     <= '0;
        sum_q        <= '0;
        hdr_q        <= '0;
        pending_q    <= '0;
        mac_q        <= '0;
        ip_q         <= '0;
        ports_q      <= '0;
      end else begin
        udp_len_q    <= udp_len_d;
        port_match_q <= port_match_d;
        opcode_q     <= opcode_d;
        sum_q        <= sum_d;
        hdr_q        <= hdr_d;
        pending_q    <= pending_d;
        mac_q        <= mac_d;
        ip_q         <= ip_d;
        ports_q      <= ports_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o && e.last) begin
        fin_valid_q <= 1'b1;
      end else if (fin_move) begin
        fin_valid_q <= 1'b0;
      end
      if (fin_move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && e.last) begin
      fin_ok_q  <= ok;
      fin_fwd_q <= e.fwd;
      fin_req_q <= opcode_d == OP_REQUEST;
      fin_off_q <= e.udp_off;
      fin_mac_q <= mac_d;
      fin_ip_q  <= ip_d;
      fin_sum_q <= sum_d;
      fin_hdr_q <= hdr_d;
    end
    if (fin_move) begin
      out_item_q <= out_item_d;
    end
  end

endmodule

@@ sv/dhcp_frame_classify_checksum.sv @@
// Top level of the DHCP frame classifier with UDP checksum rebuild.
// Instantiates dfcc_front, dfcc_queue and dfcc_back; depends on dfcc_pkg.
//
// The block takes one frame byte per request and sustains one request per cycle while its
// queue is not full. Every byte is tagged by the front end and handed through a short queue
// to the back end, which updates the checksum with at most one 16-bit ones'-complement
// addition per byte; that addition sets the rate. A frame's result passes through the
// final stage and output registers, and the QUEUE_DEPTH-entry queue lets input go on while
// a result waits on a stalled output. Frames longer than MAX_FRAME_BYTES are rejected.
module dhcp_frame_classify_checksum
  import dfcc_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = 2048,
  parameter int unsigned QUEUE_DEPTH     = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic     q_full, q_push, q_pop, q_valid;
  q_entry_t q_entry_in, q_entry_out;

  dfcc_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i (in_data_i),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_entry_o (q_entry_in)
  );

  dfcc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .entry_i(q_entry_in),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .entry_o(q_entry_out)
  );

  dfcc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_entry_i  (q_entry_out),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule
